### rtl/core/dcfe_pkg.sv
// Package for the drive command frame encoder.
// Holds the queue entry type, frame constants and the CRC-16/MODBUS byte step.
// No dependencies.
package dcfe_pkg;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] flags;
    } t_entry;

    localparam logic [2:0] CMD_STOP       = 3'd0;
    localparam logic [2:0] CMD_FORWARD    = 3'd1;
    localparam logic [2:0] CMD_BACKWARD   = 3'd2;
    localparam logic [2:0] CMD_TURN_LEFT  = 3'd3;
    localparam logic [2:0] CMD_TURN_RIGHT = 3'd4;
    localparam logic [2:0] CMD_RAW        = 3'd5;

    localparam logic [7:0] FLAGS_STOP       = 8'h01;
    localparam logic [7:0] FLAGS_FORWARD    = 8'hF1;
    localparam logic [7:0] FLAGS_BACKWARD   = 8'hA1;
    localparam logic [7:0] FLAGS_TURN_LEFT  = 8'hB1;
    localparam logic [7:0] FLAGS_TURN_RIGHT = 8'hE1;

    localparam logic [7:0] FRAME_START = 8'hFF;
    localparam logic [7:0] FRAME_KIND  = 8'h07;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte positions within the frame
    localparam logic [3:0] POS_START   = 4'd0;
    localparam logic [3:0] POS_KIND    = 4'd1;
    localparam logic [3:0] POS_LEFT    = 4'd2;
    localparam logic [3:0] POS_PAD_L   = 4'd3;
    localparam logic [3:0] POS_RIGHT   = 4'd4;
    localparam logic [3:0] POS_PAD_R   = 4'd5;
    localparam logic [3:0] POS_FLAGS   = 4'd6;
    localparam logic [3:0] POS_CRC_LO  = 4'd7;
    localparam logic [3:0] POS_CRC_HI  = 4'd8;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/drive_command_frame_encoder.sv
// Top level of the drive command frame encoder.
// Instantiates dcfe_front, dcfe_queue and dcfe_back; depends on dcfe_pkg.
//
// Each accepted request is one motor command; the block answers with a
// nine-byte frame on the master stream, one byte per beat: 0xFF, 0x07,
// left speed, 0x00, right speed, 0x00, flags, then the CRC-16/MODBUS
// (init 0xFFFF, reflected polynomial 0xA001) low and high byte taken over
// bytes 1 to 6. tlast marks the CRC high byte. Stop and the unused command
// codes 6 and 7 send zero speeds with flags 0x01; turn commands send the
// left speed on both wheels; raw sends raw_flags as the flag byte. Rate:
// one byte per cycle while the output is not stalled, set by the back-end
// serializer that emits a byte and advances the CRC in the same cycle. The
// front end resolves a request into a queue entry and keeps accepting while
// the back end still streams an earlier frame, until the queue (QUEUE_DEPTH
// entries) plus the front register are full. An accepted request passes
// through the front register and the queue before the back end registers
// the first byte of its frame. Output beats come from a register, so
// downstream stalls hold tdata and tlast steady.
module drive_command_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] left_vel, [15:8] right_vel, [23:16] raw_flags
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tlast    // last_byte
);
    import dcfe_pkg::*;

    logic   front_push;
    logic   queue_push_ready;
    t_entry front_entry;
    logic   queue_valid;
    logic   back_pop;
    t_entry queue_entry;

    // Resolve speeds and flags for each request
    dcfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_left_vel    (s_axis_tdata[7:0]),
        .i_right_vel   (s_axis_tdata[15:8]),
        .i_raw_flags   (s_axis_tdata[23:16]),
        .o_push        (front_push),
        .i_push_ready  (queue_push_ready),
        .o_entry       (front_entry)
    );

    // Decouple intake from the byte serializer
    dcfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (queue_push_ready),
        .i_entry      (front_entry),
        .o_valid      (queue_valid),
        .i_pop        (back_pop),
        .o_entry      (queue_entry)
    );

    // Stream the frame; drop the queue head after its CRC high byte
    dcfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_entry (queue_entry),
        .o_pop   (back_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

### rtl/core/dcfe_front.sv
// Front end of the drive command frame encoder: accepts commands and
// resolves speeds and flags into a queue entry. Depends on dcfe_pkg.
module dcfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_cmd,
    input  logic [7:0]      i_left_vel,
    input  logic [7:0]      i_right_vel,
    input  logic [7:0]      i_raw_flags,
    output logic            o_push,
    input  logic            i_push_ready,
    output dcfe_pkg::t_entry o_entry
);
    import dcfe_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry.left  = i_left_vel;
        n_entry.right = i_right_vel;
        case (i_cmd)
            CMD_FORWARD:    n_entry.flags = FLAGS_FORWARD;
            CMD_BACKWARD:   n_entry.flags = FLAGS_BACKWARD;
            CMD_TURN_LEFT: begin
                n_entry.right = i_left_vel;
                n_entry.flags = FLAGS_TURN_LEFT;
            end
            CMD_TURN_RIGHT: begin
                n_entry.right = i_left_vel;
                n_entry.flags = FLAGS_TURN_RIGHT;
            end
            CMD_RAW:        n_entry.flags = i_raw_flags;
            default: begin
                // stop and unused codes: force both wheels to zero
                n_entry.left  = 8'h00;
                n_entry.right = 8'h00;
                n_entry.flags = FLAGS_STOP;
            end
        endcase
    end

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_entry <= n_entry;
        end
    end

endmodule

### rtl/core/dcfe_queue.sv
// Short FIFO of resolved commands between front and back end.
// Depends on dcfe_pkg.
module dcfe_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  dcfe_pkg::t_entry i_entry,
    output logic             o_valid,
    input  logic             i_pop,
    output dcfe_pkg::t_entry o_entry
);
    import dcfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_entry      = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### rtl/core/dcfe_back.sv
// Back end of the drive command frame encoder: serializes one queue entry
// into nine frame bytes and folds the CRC in as bytes go out. Depends on dcfe_pkg.
module dcfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dcfe_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last
);
    import dcfe_pkg::*;

    logic [3:0]  r_pos;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [7:0]  n_byte;
    logic        advance;

    assign advance = i_valid && (!r_out_valid || i_ready);
    assign o_pop   = advance && (r_pos == POS_CRC_HI);

    always_comb begin
        case (r_pos)
            POS_START:  n_byte = FRAME_START;
            POS_KIND:   n_byte = FRAME_KIND;
            POS_LEFT:   n_byte = i_entry.left;
            POS_PAD_L:  n_byte = 8'h00;
            POS_RIGHT:  n_byte = i_entry.right;
            POS_PAD_R:  n_byte = 8'h00;
            POS_FLAGS:  n_byte = i_entry.flags;
            POS_CRC_LO: n_byte = r_crc[7:0];
            POS_CRC_HI: n_byte = r_crc[15:8];
            default:    n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_START;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (r_pos == POS_CRC_HI) begin
                    r_pos <= POS_START;
                    r_crc <= CRC_INIT;
                end else begin
                    r_pos <= r_pos + 1'b1;
                    // fold the bytes after the start marker up to the flags
                    if (r_pos inside {[POS_KIND:POS_FLAGS]}) begin
                        r_crc <= crc_byte(r_crc, n_byte);
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_byte;
            r_out_last <= (r_pos == POS_CRC_HI);
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

### rtl/core/dcfe_checker.sv
// Port-level checker for the drive command frame encoder, bound to the top.
// Depends on the drive_command_frame_encoder port list only.
module dcfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [3:0] r_beat;
    logic [7:0] r_pending;
    logic       in_acc;
    logic       out_acc;
    logic       frame_done;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_acc    = m_axis_tvalid && m_axis_tready;
    assign frame_done = out_acc && m_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat    <= 4'd0;
            r_pending <= 8'd0;
        end else begin
            if (out_acc) begin
                r_beat <= m_axis_tlast ? 4'd0 : r_beat + 4'd1;
            end
            if (in_acc && !frame_done) begin
                r_pending <= r_pending + 8'd1;
            end else if (frame_done && !in_acc) begin
                r_pending <= r_pending - 8'd1;
            end
        end
    end

    // tlast sits on the ninth byte of every frame and nowhere else
    a_last_on_ninth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_beat == 4'd8)))
        else $error("tlast not on ninth frame byte");

    a_start_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_beat == 4'd0) |-> (m_axis_tdata == 8'hFF))
        else $error("frame does not open with start byte");

    a_kind_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_beat == 4'd1) |-> (m_axis_tdata == 8'h07))
        else $error("second frame byte is not the kind byte");

    // no frame bytes without an accepted request behind them
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != 8'd0))
        else $error("output beat without outstanding request");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind drive_command_frame_encoder dcfe_checker u_dcfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
